[hdl/hpuip_pkg.sv]
`default_nettype none
package hpuip_pkg;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UNI,
    S_LO_MOD,
    S_DRAW,
    S_HASH_CTR,
    S_HASH_SEED,
    S_CHECK,
    S_RES_MOD,
    S_POST,
    S_SCAN,
    S_CMP,
    S_OUT
  } state_t;

  localparam logic [1:0] KIND_RESTART = 2'd0;
  localparam logic [1:0] KIND_DRAW    = 2'd1;
  localparam logic [1:0] KIND_PICK    = 2'd2;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_SHORT = 1'b1;

  localparam logic [31:0] HALF_RANGE = 32'h8000_0000;
  localparam logic [31:0] ALL_ONES   = 32'hFFFF_FFFF;
  localparam logic [31:0] PAD_WORD   = 32'h8000_0000;
  localparam logic [31:0] LEN_SEED   = 32'd256;
  localparam logic [31:0] LEN_CTR    = 32'd288;
  localparam logic [2:0]  LAST_WORD  = 3'd7;

  typedef struct packed {
    logic start;
    logic with_ctr;
  } sha_cmd_t;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } mod_cmd_t;

  localparam logic [31:0] SHA_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] SHA_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage
`default_nettype wire

[hdl/hash_prng_unique_index_picker_unit.sv]
// restart: result registered on accept; draw: a remainder for the rejection threshold, then
// raw words taken from the hash until one passes, then a remainder (no threshold above 2^31,
// result 0 for a bound below 2), with a block rehash every eighth word and a seed rehash on counter wrap
// pick: one draw per candidate plus a scan of the indices already kept (duplicate scan)
// one item at a time; the shared hash round unit and the 1-bit/cycle remainder unit set the rate
// rst (synchronous) clears seed, hash, counters and vector registers; no clearing pass
`default_nettype none
module hash_prng_unique_index_picker_unit #(
  parameter int MAX_PICKS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        req_valid,
  output logic             req_stall,
  input  wire logic [1:0]  kind,
  input  wire logic [31:0] bound,
  input  wire logic [30:0] list_size,
  input  wire logic [6:0]  pick_count,
  output logic             rsp_valid,
  input  wire logic        rsp_stall,
  output logic [31:0]      value,
  output logic             status,
  output logic             last,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);

  localparam int CW = $clog2(MAX_PICKS + 1);
  localparam int AW = (MAX_PICKS > 1) ? $clog2(MAX_PICKS) : 1;

  hpuip_pkg::state_t   state, state_next;
  hpuip_pkg::sha_cmd_t sha_cmd;
  hpuip_pkg::mod_cmd_t mod_cmd;

  logic [63:0]   iv_q [4];
  logic [255:0]  seed;
  logic [255:0]  hash;
  logic [31:0]   ctr;
  logic [2:0]    wi;
  logic [CW-1:0] total;
  logic [CW-1:0] n_q;
  logic [CW-1:0] scan_idx;
  logic          pick_q;
  logic [31:0]   ub;
  logic [31:0]   lo;
  logic [31:0]   r_raw;
  logic [31:0]   res;
  logic [30:0]   mem [MAX_PICKS];
  logic [30:0]   rd_data;

  logic          sha_done;
  logic [255:0]  sha_digest;
  logic          mod_done;
  logic [31:0]   mod_rem;

  logic          accept;
  logic [6:0]    n_in7;
  logic [CW-1:0] nclamp;
  logic          list_short;
  logic [31:0]   word;
  logic          load_out;
  logic [31:0]   out_value;
  logic          out_status;
  logic          out_last;
  logic          mem_we;

  function automatic logic [2:0] LAST_WORD_SEL(input logic [2:0] j);
    return hpuip_pkg::LAST_WORD - j;
  endfunction

  assign cfg_ready  = 1'b1;
  assign req_stall  = (state != hpuip_pkg::S_IDLE);
  assign accept     = req_valid && !req_stall;
  assign n_in7      = (pick_count > 7'(MAX_PICKS)) ? 7'(MAX_PICKS) : pick_count;
  assign nclamp     = CW'(n_in7);
  assign list_short = list_size < {24'd0, n_in7};
  assign word       = hash[{LAST_WORD_SEL(wi), 5'd0} +: 32];

  hpuip_sha u_sha (
    .clk    (clk),
    .rst    (rst),
    .cmd    (sha_cmd),
    .seed   (seed),
    .ctr    (ctr),
    .done   (sha_done),
    .digest (sha_digest)
  );

  hpuip_mod u_mod (
    .clk  (clk),
    .rst  (rst),
    .cmd  (mod_cmd),
    .done (mod_done),
    .rem  (mod_rem)
  );

  always_comb begin
    state_next = state;
    case (state)
      hpuip_pkg::S_IDLE: begin
        if (accept) begin
          case (kind)
            hpuip_pkg::KIND_RESTART: state_next = hpuip_pkg::S_OUT;
            hpuip_pkg::KIND_DRAW:    state_next = hpuip_pkg::S_UNI;
            hpuip_pkg::KIND_PICK: begin
              if (list_short) begin
                state_next = hpuip_pkg::S_OUT;
              end else if (nclamp != '0) begin
                state_next = hpuip_pkg::S_UNI;
              end
            end
            default: state_next = hpuip_pkg::S_IDLE;
          endcase
        end
      end
      hpuip_pkg::S_UNI: begin
        if (ub < 32'd2) begin
          state_next = hpuip_pkg::S_POST;
        end else if (ub > hpuip_pkg::HALF_RANGE) begin
          state_next = hpuip_pkg::S_DRAW;
        end else begin
          state_next = hpuip_pkg::S_LO_MOD;
        end
      end
      hpuip_pkg::S_LO_MOD: begin
        if (mod_done) state_next = hpuip_pkg::S_DRAW;
      end
      hpuip_pkg::S_DRAW: begin
        state_next = (wi == hpuip_pkg::LAST_WORD) ? hpuip_pkg::S_HASH_CTR : hpuip_pkg::S_CHECK;
      end
      hpuip_pkg::S_HASH_CTR: begin
        if (sha_done) begin
          state_next = (ctr == hpuip_pkg::ALL_ONES) ? hpuip_pkg::S_HASH_SEED
                                                     : hpuip_pkg::S_CHECK;
        end
      end
      hpuip_pkg::S_HASH_SEED: begin
        if (sha_done) state_next = hpuip_pkg::S_CHECK;
      end
      hpuip_pkg::S_CHECK: begin
        state_next = (r_raw < lo) ? hpuip_pkg::S_DRAW : hpuip_pkg::S_RES_MOD;
      end
      hpuip_pkg::S_RES_MOD: begin
        if (mod_done) state_next = hpuip_pkg::S_POST;
      end
      hpuip_pkg::S_POST: begin
        state_next = pick_q ? hpuip_pkg::S_SCAN : hpuip_pkg::S_OUT;
      end
      hpuip_pkg::S_SCAN: begin
        state_next = (scan_idx == total) ? hpuip_pkg::S_OUT : hpuip_pkg::S_CMP;
      end
      hpuip_pkg::S_CMP: begin
        state_next = (rd_data == res[30:0]) ? hpuip_pkg::S_UNI : hpuip_pkg::S_SCAN;
      end
      hpuip_pkg::S_OUT: begin
        if (rsp_valid && !rsp_stall) begin
          state_next = last ? hpuip_pkg::S_IDLE : hpuip_pkg::S_UNI;
        end
      end
      default: state_next = hpuip_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    sha_cmd.start    = 1'b0;
    sha_cmd.with_ctr = (state == hpuip_pkg::S_DRAW);
    mod_cmd.start    = 1'b0;
    mod_cmd.dividend = r_raw;
    mod_cmd.divisor  = ub;
    load_out         = 1'b0;
    out_value        = 32'd0;
    out_status       = hpuip_pkg::STATUS_OK;
    out_last         = 1'b1;
    mem_we           = 1'b0;
    case (state)
      hpuip_pkg::S_IDLE: begin
        if (accept && kind == hpuip_pkg::KIND_RESTART) begin
          load_out = 1'b1;
        end else if (accept && kind == hpuip_pkg::KIND_PICK && list_short) begin
          load_out   = 1'b1;
          out_status = hpuip_pkg::STATUS_SHORT;
        end
      end
      hpuip_pkg::S_UNI: begin
        // threshold (2^32 - 2*bound) mod bound
        if (ub >= 32'd2 && ub <= hpuip_pkg::HALF_RANGE) begin
          mod_cmd.start    = 1'b1;
          mod_cmd.dividend = 32'd0 - {ub[30:0], 1'b0};
        end
      end
      hpuip_pkg::S_DRAW: begin
        sha_cmd.start = (wi == hpuip_pkg::LAST_WORD);
      end
      hpuip_pkg::S_HASH_CTR: begin
        sha_cmd.start = sha_done && (ctr == hpuip_pkg::ALL_ONES);
      end
      hpuip_pkg::S_CHECK: begin
        mod_cmd.start = (r_raw >= lo);
      end
      hpuip_pkg::S_POST: begin
        if (!pick_q) begin
          load_out  = 1'b1;
          out_value = res;
        end
      end
      hpuip_pkg::S_SCAN: begin
        if (scan_idx == total) begin
          load_out  = 1'b1;
          mem_we    = 1'b1;
          out_value = res;
          out_last  = (total + CW'(1)) == n_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= hpuip_pkg::S_IDLE;
      seed      <= '0;
      hash      <= '0;
      ctr       <= 32'd0;
      wi        <= 3'd0;
      total     <= '0;
      rsp_valid <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        iv_q[i] <= 64'd0;
      end
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        iv_q[cfg_index] <= cfg_data;
      end
      case (state)
        hpuip_pkg::S_IDLE: begin
          if (accept && kind == hpuip_pkg::KIND_RESTART) begin
            seed <= {iv_q[0], iv_q[1], iv_q[2], iv_q[3]};
            hash <= {iv_q[0], iv_q[1], iv_q[2], iv_q[3]};
            ctr  <= 32'd0;
            wi   <= 3'd0;
          end
          if (accept && kind == hpuip_pkg::KIND_PICK) begin
            total <= '0;
          end
        end
        hpuip_pkg::S_DRAW: begin
          wi <= wi + 3'd1;
        end
        hpuip_pkg::S_HASH_CTR: begin
          if (sha_done) begin
            hash <= sha_digest;
            ctr  <= ctr + 32'd1;
          end
        end
        hpuip_pkg::S_HASH_SEED: begin
          if (sha_done) begin
            seed <= sha_digest;
            hash <= sha_digest;
            ctr  <= 32'd0;
          end
        end
        hpuip_pkg::S_SCAN: begin
          if (scan_idx == total) begin
            total <= total + CW'(1);
          end
        end
        default: begin
        end
      endcase
      if (load_out) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      value  <= out_value;
      status <= out_status;
      last   <= out_last;
    end
    case (state)
      hpuip_pkg::S_IDLE: begin
        if (accept) begin
          pick_q <= (kind == hpuip_pkg::KIND_PICK);
          ub     <= (kind == hpuip_pkg::KIND_PICK) ? {1'b0, list_size} : bound;
          n_q    <= nclamp;
        end
      end
      hpuip_pkg::S_UNI: begin
        if (ub < 32'd2) begin
          res <= 32'd0;
        end else if (ub > hpuip_pkg::HALF_RANGE) begin
          lo <= 32'd0 - ub;
        end
      end
      hpuip_pkg::S_LO_MOD: begin
        if (mod_done) lo <= mod_rem;
      end
      hpuip_pkg::S_DRAW: begin
        r_raw <= word;
      end
      hpuip_pkg::S_RES_MOD: begin
        if (mod_done) res <= mod_rem;
      end
      hpuip_pkg::S_POST: begin
        scan_idx <= '0;
      end
      hpuip_pkg::S_CMP: begin
        scan_idx <= scan_idx + CW'(1);
      end
      default: begin
      end
    endcase
  end

  // picked index store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[total[AW-1:0]] <= res[30:0];
    end
    rd_data <= mem[scan_idx[AW-1:0]];
  end

endmodule
`default_nettype wire

[hdl/hpuip_sha.sv]
`default_nettype none
module hpuip_sha (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire hpuip_pkg::sha_cmd_t cmd,
  input  wire logic [255:0]       seed,
  input  wire logic [31:0]        ctr,
  output logic                    done,
  output logic [255:0]            digest
);

  logic        busy;
  logic        fin;
  logic [5:0]  round;
  logic [31:0] va, vb, vc, vd, ve, vf, vg, vh;
  logic [31:0] w [16];
  logic [31:0] blk [16];
  logic [31:0] s1e, ch, t1, s0a, maj, t2, ws0, ws1, wn;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      blk[i] = seed[255 - 32 * i -: 32];
    end
    for (int i = 8; i < 16; i++) begin
      blk[i] = 32'd0;
    end
    if (cmd.with_ctr) begin
      blk[8]  = ctr;
      blk[9]  = hpuip_pkg::PAD_WORD;
      blk[15] = hpuip_pkg::LEN_CTR;
    end else begin
      blk[8]  = hpuip_pkg::PAD_WORD;
      blk[15] = hpuip_pkg::LEN_SEED;
    end
  end

  always_comb begin
    s1e = hpuip_pkg::rotr(ve, 6) ^ hpuip_pkg::rotr(ve, 11) ^ hpuip_pkg::rotr(ve, 25);
    ch  = (ve & vf) ^ (~ve & vg);
    t1  = vh + s1e + ch + hpuip_pkg::SHA_K[round] + w[0];
    s0a = hpuip_pkg::rotr(va, 2) ^ hpuip_pkg::rotr(va, 13) ^ hpuip_pkg::rotr(va, 22);
    maj = (va & vb) ^ (va & vc) ^ (vb & vc);
    t2  = s0a + maj;
    ws0 = hpuip_pkg::rotr(w[1], 7) ^ hpuip_pkg::rotr(w[1], 18) ^ (w[1] >> 3);
    ws1 = hpuip_pkg::rotr(w[14], 17) ^ hpuip_pkg::rotr(w[14], 19) ^ (w[14] >> 10);
    wn  = w[0] + ws0 + w[9] + ws1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      fin   <= 1'b0;
      done  <= 1'b0;
      round <= 6'd0;
    end else begin
      done <= 1'b0;
      fin  <= 1'b0;
      if (cmd.start) begin
        busy  <= 1'b1;
        round <= 6'd0;
      end else if (busy) begin
        round <= round + 6'd1;
        if (round == 6'd63) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end
      if (fin) begin
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      va <= hpuip_pkg::SHA_IV[0];
      vb <= hpuip_pkg::SHA_IV[1];
      vc <= hpuip_pkg::SHA_IV[2];
      vd <= hpuip_pkg::SHA_IV[3];
      ve <= hpuip_pkg::SHA_IV[4];
      vf <= hpuip_pkg::SHA_IV[5];
      vg <= hpuip_pkg::SHA_IV[6];
      vh <= hpuip_pkg::SHA_IV[7];
      for (int i = 0; i < 16; i++) begin
        w[i] <= blk[i];
      end
    end else if (busy) begin
      va <= t1 + t2;
      vb <= va;
      vc <= vb;
      vd <= vc;
      ve <= vd + t1;
      vf <= ve;
      vg <= vf;
      vh <= vg;
      for (int i = 0; i < 15; i++) begin
        w[i] <= w[i + 1];
      end
      w[15] <= wn;
    end
    if (fin) begin
      digest <= {hpuip_pkg::SHA_IV[0] + va, hpuip_pkg::SHA_IV[1] + vb,
                 hpuip_pkg::SHA_IV[2] + vc, hpuip_pkg::SHA_IV[3] + vd,
                 hpuip_pkg::SHA_IV[4] + ve, hpuip_pkg::SHA_IV[5] + vf,
                 hpuip_pkg::SHA_IV[6] + vg, hpuip_pkg::SHA_IV[7] + vh};
    end
  end

endmodule
`default_nettype wire

[hdl/hpuip_mod.sv]
`default_nettype none
module hpuip_mod (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire hpuip_pkg::mod_cmd_t cmd,
  output logic                    done,
  output logic [31:0]             rem
);

  logic        busy;
  logic [4:0]  cnt;
  logic [31:0] dvd;
  logic [31:0] dvs;
  logic [32:0] shifted;
  logic [32:0] diff;
  logic        ge;

  // one quotient bit per cycle, restoring
  always_comb begin
    shifted = {rem, dvd[31]};
    diff    = shifted - {1'b0, dvs};
    ge      = shifted >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 5'd0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
        cnt  <= 5'd0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      rem <= 32'd0;
      dvd <= cmd.dividend;
      dvs <= cmd.divisor;
    end else if (busy) begin
      rem <= ge ? diff[31:0] : shifted[31:0];
      dvd <= {dvd[30:0], 1'b0};
    end
  end

endmodule
`default_nettype wire

[hdl/hpuip_chk.sv]
`default_nettype none
module hpuip_chk (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        req_valid,
  input wire logic        req_stall,
  input wire logic        rsp_valid,
  input wire logic        rsp_stall,
  input wire logic [31:0] value,
  input wire logic        status,
  input wire logic        last
);

  // error item carries zero and ends the item's results
  a_err_form: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status |-> value == 32'd0 && last)
    else $error("error result malformed");

  // no new item while a result is pending
  a_busy_out: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> req_stall)
    else $error("input taken with result pending");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(value) && $stable(status) && $stable(last))
    else $error("stalled result changed");

  a_reset: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result valid after reset");

endmodule

bind hash_prng_unique_index_picker_unit hpuip_chk u_chk (.*);
`default_nettype wire
